// ===== hw/rtl/macd_pkg.sv =====
// Shared types, constants and helpers for the moving average crossover detector.
package macd_pkg;

    localparam int MAX_WINDOW_DEF = 64;
    localparam int PRICE_BITS_DEF = 32;

    localparam int LEN_W   = 7;
    localparam int TOTAL_W = 38;
    localparam int TAG_W   = 16;
    localparam int PRICE_W = 32;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [LEN_W-1:0] SHORT_LEN_RST = 7'd10;
    localparam logic [LEN_W-1:0] LONG_LEN_RST  = 7'd50;

    localparam logic REG_SHORT = 1'b0;
    localparam logic REG_LONG  = 1'b1;

    localparam logic [1:0] NO_CROSS   = 2'd0;
    localparam logic [1:0] CROSS_UP   = 2'd1;
    localparam logic [1:0] CROSS_DOWN = 2'd2;

    typedef enum logic [1:0] {
        REL_EQUAL   = 2'd0,
        REL_LESS    = 2'd1,
        REL_GREATER = 2'd2
    } rel_t;

    typedef struct packed {
        logic [PRICE_W-1:0] price_sample;
        logic [TAG_W-1:0]   stream_tag;
    } in_t;

    typedef struct packed {
        logic               analysis_valid;
        logic [1:0]         cross_signal;
        logic               sustained_rise;
        logic [TOTAL_W-1:0] short_total;
        logic [TOTAL_W-1:0] long_total;
        logic [TAG_W-1:0]   tag_out;
    } out_t;

    typedef struct packed {
        logic             clear;
        logic [LEN_W-1:0] short_len;
        logic [LEN_W-1:0] long_len;
    } cfg_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len,
                                                   input int unsigned max_w);
        logic [LEN_W-1:0] res;
        res = len;
        if (len == '0) begin
            res = LEN_W'(1);
        end else if (32'(len) > max_w) begin
            res = LEN_W'(max_w);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/macd_window.sv =====
// Sample history memory and running window sums.
module macd_window import macd_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int SUM_W      = PRICE_BITS + $clog2(MAX_WINDOW)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             w_valid,
    input  logic             w_ready,
    output logic [SUM_W-1:0] w_short_sum,
    output logic [SUM_W-1:0] w_long_sum,
    output logic             w_analysis_valid,
    output logic [TAG_W-1:0] w_tag
);

    localparam int SLOT_W = $clog2(MAX_WINDOW);
    localparam int CNT_W  = $clog2(MAX_WINDOW + 2);
    localparam int WRAP_W = SLOT_W + 1;

    logic [PRICE_BITS-1:0] mem [MAX_WINDOW];

    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [PRICE_BITS-1:0] rd_s_reg, rd_l_reg;
    logic                  s1_valid_reg;
    logic [PRICE_BITS-1:0] s1_price_reg;
    logic [TAG_W-1:0]      s1_tag_reg;
    logic [CNT_W-1:0]      s1_cnt_reg;
    logic [SUM_W-1:0]      acc_s_reg, acc_s_next, acc_l_reg, acc_l_next;
    logic                  s2_valid_reg;
    logic [SUM_W-1:0]      s2_short_reg, s2_long_reg;
    logic                  s2_aval_reg;
    logic [TAG_W-1:0]      s2_tag_reg;

    logic                  accept, adv1, adv2;
    logic [PRICE_BITS-1:0] price_in;
    logic [SLOT_W-1:0]     addr_s, addr_l;
    logic [WRAP_W-1:0]     wrap_s, wrap_l;
    logic [SUM_W-1:0]      drop_s, drop_l;

    assign adv2    = s2_valid_reg && w_ready;
    assign adv1    = s1_valid_reg && (!s2_valid_reg || adv2);
    assign s_ready = !s1_valid_reg || adv1;
    assign accept  = s_valid && s_ready;

    assign price_in = PRICE_BITS'(s_data.price_sample);

    always_comb begin
        wrap_s = {1'b0, slot_reg} + WRAP_W'(MAX_WINDOW) - WRAP_W'(cfg.short_len);
        wrap_l = {1'b0, slot_reg} + WRAP_W'(MAX_WINDOW) - WRAP_W'(cfg.long_len);
        if (wrap_s >= WRAP_W'(MAX_WINDOW)) begin
            wrap_s = wrap_s - WRAP_W'(MAX_WINDOW);
        end
        if (wrap_l >= WRAP_W'(MAX_WINDOW)) begin
            wrap_l = wrap_l - WRAP_W'(MAX_WINDOW);
        end
        addr_s = wrap_s[SLOT_W-1:0];
        addr_l = wrap_l[SLOT_W-1:0];
    end

    always_comb begin
        slot_next = (32'(slot_reg) == MAX_WINDOW - 1) ? '0 : slot_reg + SLOT_W'(1);
        cnt_next  = (32'(cnt_reg) < MAX_WINDOW + 1) ? cnt_reg + CNT_W'(1) : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mem[slot_reg] <= price_in;
            rd_s_reg      <= mem[addr_s];
            rd_l_reg      <= mem[addr_l];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.clear) begin
            slot_reg <= '0;
            cnt_reg  <= '0;
        end else if (accept) begin
            slot_reg <= slot_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_price_reg <= price_in;
            s1_tag_reg   <= s_data.stream_tag;
            s1_cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        drop_s = (32'(s1_cnt_reg) > 32'(cfg.short_len)) ? SUM_W'(rd_s_reg) : '0;
        drop_l = (32'(s1_cnt_reg) > 32'(cfg.long_len))  ? SUM_W'(rd_l_reg) : '0;
        acc_s_next = acc_s_reg + SUM_W'(s1_price_reg) - drop_s;
        acc_l_next = acc_l_reg + SUM_W'(s1_price_reg) - drop_l;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.clear) begin
            acc_s_reg <= '0;
            acc_l_reg <= '0;
        end else if (adv1) begin
            acc_s_reg <= acc_s_next;
            acc_l_reg <= acc_l_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (!s2_valid_reg || adv2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            s2_short_reg <= (32'(s1_cnt_reg) >= 32'(cfg.short_len)) ? acc_s_next : '0;
            s2_long_reg  <= (32'(s1_cnt_reg) >= 32'(cfg.long_len))  ? acc_l_next : '0;
            s2_aval_reg  <= 32'(s1_cnt_reg) >= 32'(cfg.long_len);
            s2_tag_reg   <= s1_tag_reg;
        end
    end

    assign w_valid          = s2_valid_reg;
    assign w_short_sum      = s2_short_reg;
    assign w_long_sum       = s2_long_reg;
    assign w_analysis_valid = s2_aval_reg;
    assign w_tag            = s2_tag_reg;

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cnt_reg) <= MAX_WINDOW + 1)
        else $error("sample count beyond saturation");

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(slot_reg) < MAX_WINDOW)
        else $error("write slot out of range");

    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg.clear |=> (cnt_reg == '0) && (acc_s_reg == '0) && (acc_l_reg == '0))
        else $error("history not cleared after register write");
`endif

endmodule

// ===== hw/rtl/macd_cross.sv =====
// Cross-multiplied average compare, crossover decision and result register.
module macd_cross import macd_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF,
    parameter int SUM_W      = PRICE_BITS + $clog2(MAX_WINDOW)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cfg_t             cfg,
    input  logic             w_valid,
    output logic             w_ready,
    input  logic [SUM_W-1:0] w_short_sum,
    input  logic [SUM_W-1:0] w_long_sum,
    input  logic             w_analysis_valid,
    input  logic [TAG_W-1:0] w_tag,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    localparam int PROD_W = SUM_W + LEN_W;

    logic              m_valid_reg;
    out_t              m_data_reg, m_data_next;
    rel_t              prev_rel_reg, cur_rel;
    logic [PROD_W-1:0] prod_s, prod_l;
    logic              accept;

    assign w_ready = !m_valid_reg || m_ready;
    assign accept  = w_valid && w_ready;

    assign prod_s = PROD_W'(w_short_sum) * PROD_W'(cfg.long_len);
    assign prod_l = PROD_W'(w_long_sum) * PROD_W'(cfg.short_len);

    always_comb begin
        if (prod_s < prod_l) begin
            cur_rel = REL_LESS;
        end else if (prod_s > prod_l) begin
            cur_rel = REL_GREATER;
        end else begin
            cur_rel = REL_EQUAL;
        end
    end

    always_comb begin
        m_data_next                = '0;
        m_data_next.analysis_valid = w_analysis_valid;
        m_data_next.short_total    = TOTAL_W'(w_short_sum);
        m_data_next.long_total     = TOTAL_W'(w_long_sum);
        m_data_next.tag_out        = w_tag;
        m_data_next.cross_signal   = NO_CROSS;
        if (w_analysis_valid) begin
            if (prev_rel_reg == REL_LESS && cur_rel == REL_GREATER) begin
                m_data_next.cross_signal = CROSS_UP;
            end else if (prev_rel_reg == REL_GREATER && cur_rel == REL_LESS) begin
                m_data_next.cross_signal = CROSS_DOWN;
            end else if (prev_rel_reg == REL_GREATER && cur_rel == REL_GREATER) begin
                m_data_next.cross_signal   = CROSS_UP;
                m_data_next.sustained_rise = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg.clear) begin
            prev_rel_reg <= REL_EQUAL;
        end else if (accept) begin
            prev_rel_reg <= cur_rel;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (w_ready) begin
            m_valid_reg <= w_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_rise_golden: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.sustained_rise |-> m_data_reg.cross_signal == CROSS_UP)
        else $error("sustained rise without upward cross");

    a_signal_needs_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (m_data_reg.cross_signal != NO_CROSS) |-> m_data_reg.analysis_valid)
        else $error("cross reported before long window filled");

    a_rel_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !cfg.clear |=> prev_rel_reg == $past(cur_rel))
        else $error("previous relation not updated");
`endif

endmodule

// ===== hw/rtl/moving_average_crossover_detector.sv =====
// Top level: configuration registers, window sums and crossover result stage.
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    s_data  (in_t: price_sample, stream_tag)
//  m_*          out  m_valid/m_ready    m_data  (out_t: flags, sums, tag_out)
//  p*           in   psel/penable/...   short_length @0x0, long_length @0x4
//
//  One request per cycle sustained while m_ready is held high; m_ready low stalls the input.
//  Stages: history read, window sum update, cross-multiply compare into the result register.
//  Synchronous active-low reset; lengths reset to 10 and 50, history needs no clearing pass.
//  A register write clears count, slot, sums and previous relation.
//  Each stage holds while its successor is full and stalled; m_ready low fills the pipe.
module moving_average_crossover_detector import macd_pkg::*; #(
    parameter int MAX_WINDOW = MAX_WINDOW_DEF,
    parameter int PRICE_BITS = PRICE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int SUM_W = PRICE_BITS + $clog2(MAX_WINDOW);

    logic [LEN_W-1:0] short_len_reg, long_len_reg;
    logic             wr_en;
    cfg_t             cfg;

    logic             w_valid, w_ready, w_analysis_valid;
    logic [SUM_W-1:0] w_short_sum, w_long_sum;
    logic [TAG_W-1:0] w_tag;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_len_reg <= SHORT_LEN_RST;
            long_len_reg  <= LONG_LEN_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_SHORT: short_len_reg <= pwdata[LEN_W-1:0];
                REG_LONG:  long_len_reg  <= pwdata[LEN_W-1:0];
                default:   short_len_reg <= short_len_reg;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_SHORT: prdata = DATA_W'(short_len_reg);
            REG_LONG:  prdata = DATA_W'(long_len_reg);
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        cfg.clear     = wr_en;
        cfg.short_len = clamp_len(short_len_reg, MAX_WINDOW);
        cfg.long_len  = clamp_len(long_len_reg, MAX_WINDOW);
    end

    macd_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .SUM_W      (SUM_W)
    ) u_window (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data           (s_data),
        .w_valid          (w_valid),
        .w_ready          (w_ready),
        .w_short_sum      (w_short_sum),
        .w_long_sum       (w_long_sum),
        .w_analysis_valid (w_analysis_valid),
        .w_tag            (w_tag)
    );

    macd_cross #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS),
        .SUM_W      (SUM_W)
    ) u_cross (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg              (cfg),
        .w_valid          (w_valid),
        .w_ready          (w_ready),
        .w_short_sum      (w_short_sum),
        .w_long_sum       (w_long_sum),
        .w_analysis_valid (w_analysis_valid),
        .w_tag            (w_tag),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_data           (m_data)
    );

endmodule
